### hw/rtl/spad_pkg.sv
// ----------------------------------------------------------------------------
// Space packet APID demux package
// Result kinds, header layout constants and the result word type.
// ----------------------------------------------------------------------------
package spad_pkg;

  localparam int unsigned ApidW  = 11;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HdrCntW = 3;

  // index of the sixth (final) primary header byte
  localparam logic [HdrCntW-1:0] HdrLastIdx = 3'd5;

  // bit of the first halfword that flags a secondary header
  localparam int unsigned SecFlagBit = 11;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ApidW-1:0] apid;
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
  } res_t;

endpackage

### hw/rtl/space_packet_apid_demux.sv
// ----------------------------------------------------------------------------
// Space packet APID demux
// Splits a byte stream of back-to-back space packets into APID-tagged
// payload words, stripping a configured secondary header when flagged.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the skid register is empty; each
// word yields at most one registered output word. The header parser, length
// and skip counters update once per accepted word, and a two-entry output
// stage (output register plus skid register) lets input flow continue while
// the consumer stalls, until the skid register fills. Sustained rate is one
// word per cycle whenever out_ready_i is high. The secondary header size
// register is written through the cfg channel, which is always ready; write
// it only while no packet is in flight.
module space_packet_apid_demux (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [spad_pkg::SizeW-1:0]   cfg_sec_header_size_i,
  // input stream
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [spad_pkg::ByteW-1:0]   stream_byte_i,
  // output stream
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [spad_pkg::ApidW-1:0]   packet_apid_o,
  output logic [spad_pkg::ByteW-1:0]   payload_byte_o,
  output logic                         first_of_packet_o,
  output logic                         last_of_packet_o
);

  logic [spad_pkg::SizeW-1:0]   sec_size_q;
  logic                         data_phase_q, data_phase_d;
  logic [spad_pkg::HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [spad_pkg::ByteW-1:0]   hdr0_q, hdr0_d, hdr1_q, hdr1_d, hdr4_q, hdr4_d;
  logic [spad_pkg::ApidW-1:0]   apid_q, apid_d;
  logic [spad_pkg::SizeW-1:0]   left_q, left_d;
  logic [spad_pkg::SizeW-1:0]   skip_q, skip_d;
  logic                         none_q, none_d;

  spad_pkg::res_t out_q, skid_q, res;
  logic           out_valid_q, skid_valid_q;
  logic           res_valid;

  logic           in_fire, out_fire;
  logic [spad_pkg::SizeW-1:0] pkt_size;
  logic           pkt_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  assign pkt_size = {1'b0, hdr4_q, stream_byte_i} + spad_pkg::SizeW'(1);
  assign pkt_last = (left_q == spad_pkg::SizeW'(1));

  always_comb begin
    data_phase_d = data_phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr0_d       = hdr0_q;
    hdr1_d       = hdr1_q;
    hdr4_d       = hdr4_q;
    apid_d       = apid_q;
    left_d       = left_q;
    skip_d       = skip_q;
    none_d       = none_q;
    res_valid    = 1'b0;
    res.kind     = spad_pkg::KIND_PAYLOAD;
    res.apid     = apid_q;
    res.data     = '0;
    res.first    = 1'b0;
    res.last     = 1'b1;

    if (command_i == spad_pkg::CMD_END) begin
      hdr_cnt_d = '0;
      if (data_phase_q) begin
        data_phase_d = 1'b0;
        left_d       = '0;
        skip_d       = '0;
        res_valid    = 1'b1;
        res.kind     = spad_pkg::KIND_ABORT;
      end
    end else if (!data_phase_q) begin
      if (hdr_cnt_q != spad_pkg::HdrLastIdx) begin
        unique case (hdr_cnt_q)
          3'd0:    hdr0_d = stream_byte_i;
          3'd1:    hdr1_d = stream_byte_i;
          3'd4:    hdr4_d = stream_byte_i;
          default: ;  // sequence count bytes are not kept
        endcase
        hdr_cnt_d = hdr_cnt_q + 3'd1;
      end else begin
        apid_d       = {hdr0_q[2:0], hdr1_q};
        left_d       = pkt_size;
        skip_d       = (hdr0_q[spad_pkg::SecFlagBit-8] && (sec_size_q <= pkt_size))
                       ? sec_size_q : '0;
        none_d       = 1'b1;
        data_phase_d = 1'b1;
        hdr_cnt_d    = '0;
      end
    end else begin
      left_d = left_q - spad_pkg::SizeW'(1);
      if (pkt_last) data_phase_d = 1'b0;
      if (skip_q != '0) begin
        skip_d = skip_q - spad_pkg::SizeW'(1);
        if (pkt_last && none_q) begin
          res_valid = 1'b1;
          res.kind  = spad_pkg::KIND_EMPTY;
        end
      end else begin
        res_valid = 1'b1;
        res.data  = stream_byte_i;
        res.first = none_q;
        res.last  = pkt_last;
        none_d    = 1'b0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_size_q   <= '0;
      data_phase_q <= 1'b0;
      hdr_cnt_q    <= '0;
      apid_q       <= '0;
      left_q       <= '0;
      skip_q       <= '0;
      none_q       <= 1'b1;
    end else begin
      if (cfg_valid_i) sec_size_q <= cfg_sec_header_size_i;
      if (in_fire) begin
        data_phase_q <= data_phase_d;
        hdr_cnt_q    <= hdr_cnt_d;
        apid_q       <= apid_d;
        left_q       <= left_d;
        skip_q       <= skip_d;
        none_q       <= none_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hdr0_q <= hdr0_d;
      hdr1_q <= hdr1_d;
      hdr4_q <= hdr4_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) skid_valid_q <= 1'b0;
      end else if (in_fire && res_valid) begin
        if (out_valid_q && !out_ready_i) skid_valid_q <= 1'b1;
        else                             out_valid_q  <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_ready_i) skid_q <= res;
      else                             out_q  <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign packet_apid_o     = out_q.apid;
  assign payload_byte_o    = out_q.data;
  assign first_of_packet_o = out_q.first;
  assign last_of_packet_o  = out_q.last;

endmodule
